[src/dgpr_pkg.sv]
`timescale 1ns / 1ps

package dgpr_pkg;

    // Fixed point and result layout
    localparam int FRAC_BITS   = 8;
    localparam int RADIUS_W    = 12;
    localparam int XY_W        = 13;
    localparam int MASK_ROWS   = 32;
    localparam int ROW_IDX_W   = $clog2(MASK_ROWS);
    localparam int OUT_TDATA_W = 64;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ROWS,
        ST_COL,
        ST_CMP,
        ST_OUT
    } state_t;

    // Destination of the square that leaves the shared unit next cycle
    typedef enum logic [1:0] {
        DST_NONE,
        DST_R2,
        DST_ROW,
        DST_DX
    } sq_dst_t;

    // Row store write control
    typedef struct packed {
        logic                 en;
        logic [ROW_IDX_W-1:0] idx;
    } row_wr_t;

endpackage

[src/dgpr_sq_unit.sv]
`timescale 1ns / 1ps

module dgpr_sq_unit #(
    parameter int DIFF_W = 13,
    parameter int SQ_W   = 24
) (
    input  logic                     clk,
    input  logic signed [DIFF_W-1:0] operand,
    output logic        [SQ_W-1:0]   square
);

    logic [DIFF_W-2:0] mag;
    logic [SQ_W-1:0]   square_next;
    logic [SQ_W-1:0]   square_reg;

    // Take the magnitude, then square it unsigned at full product width
    always_comb
    begin
        if (operand[DIFF_W-1])
        begin
            mag = (DIFF_W-1)'(-operand);
        end
        else
        begin
            mag = operand[DIFF_W-2:0];
        end
        square_next = SQ_W'(mag) * SQ_W'(mag);
    end

    // Register the product
    always_ff @(posedge clk)
    begin
        square_reg <= square_next;
    end

    assign square = square_reg;

endmodule

[src/dgpr_row_bank.sv]
`timescale 1ns / 1ps

module dgpr_row_bank #(
    parameter int SQ_W = 24
) (
    input  logic                                clk,
    input  dgpr_pkg::row_wr_t                   wr,
    input  logic [SQ_W-1:0]                     wr_data,
    input  logic [dgpr_pkg::ROW_IDX_W-1:0]      rows_last,
    input  logic signed [SQ_W:0]                threshold,
    output logic [dgpr_pkg::MASK_ROWS-1:0]      mask
);

    import dgpr_pkg::*;

    logic [SQ_W-1:0] dy2_reg [MASK_ROWS];

    // Store the squared row distance of each row of the current circle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            dy2_reg[wr.idx] <= wr_data;
        end
    end

    // Compare every row against the column threshold in parallel
    always_comb
    begin
        for (int k = 0; k < MASK_ROWS; k++)
        begin
            mask[k] = (ROW_IDX_W'(k) <= rows_last) && !threshold[SQ_W]
                      && (dy2_reg[k] <= threshold[SQ_W-1:0]);
        end
    end

endmodule

[src/disk_grid_point_rasterizer.sv]
`timescale 1ns / 1ps
// The first column is offered once the radius and then each of the R box rows has been
// squared (R at most 32): one squaring per row through the shared multiplier.
// Each column is squared and compared before it is offered; up to 2*MAX_RADIUS+1 columns
// per circle. A new request is taken only once idle again.
// Reset: asynchronous, active low; returns the sequencer to idle with no result pending.

module disk_grid_point_rasterizer #(
    parameter int MAX_RADIUS     = 15,
    parameter int COORD_INT_BITS = 12,
    localparam int CW            = COORD_INT_BITS + dgpr_pkg::FRAC_BITS,
    localparam int IN_W          = ((2 * CW + dgpr_pkg::RADIUS_W + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // center_x [CW-1:0], center_y [2CW-1:CW], radius [2CW+11:2CW], zero fill above
    input  logic [IN_W-1:0]                     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // column_x [12:0], row_start [25:13], row_mask [57:26], zero fill above
    output logic [dgpr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // last_column
    output logic                                m_axis_tlast
);

    import dgpr_pkg::*;

    localparam int R_LIMIT = MAX_RADIUS * (1 << FRAC_BITS);
    localparam int R_W     = $clog2(R_LIMIT + 1);
    localparam int RC_W    = (R_W > RADIUS_W) ? R_W : RADIUS_W;
    localparam int DIFF_W  = $clog2(R_LIMIT + (1 << FRAC_BITS)) + 1;
    localparam int SQ_W    = 2 * (DIFF_W - 1);
    localparam int S_W     = ((CW > R_W) ? CW : R_W) + 2;
    localparam int I_W     = S_W - FRAC_BITS;
    localparam int MAXC    = 2 * MAX_RADIUS + 1;
    localparam int COL_W   = $clog2(MAXC);

    // Control registers
    state_t  state_reg, state_next;
    sq_dst_t dst_reg, dst_next;

    // Payload registers
    logic signed [CW-1:0]    cx_reg, cx_next;
    logic signed [CW-1:0]    cy_reg, cy_next;
    logic [R_W-1:0]          r_reg, r_next;
    logic [SQ_W-1:0]         r2_reg, r2_next;
    logic signed [I_W-1:0]   x_reg, x_next;
    logic signed [I_W-1:0]   x1_reg, x1_next;
    logic signed [I_W-1:0]   y0_reg, y0_next;
    logic [ROW_IDX_W-1:0]    rows_last_reg, rows_last_next;
    logic [ROW_IDX_W-1:0]    k_reg, k_next;
    logic [ROW_IDX_W-1:0]    widx_reg, widx_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [XY_W-1:0]         ocol_reg, ocol_next;
    logic [XY_W-1:0]         orow_reg, orow_next;
    logic [MASK_ROWS-1:0]    omask_reg, omask_next;
    logic                    olast_reg, olast_next;
    logic                    done_reg, done_next;

    // Datapath signals
    logic signed [S_W-1:0]   cx_ext, cy_ext, r_ext;
    logic signed [I_W-1:0]   bx0, bx1, by0, by1;
    logic signed [I_W:0]     y_span;
    logic [ROW_IDX_W-1:0]    rows_last_calc;
    logic signed [I_W:0]     yk;
    logic [RC_W-1:0]         r_in;
    logic signed [DIFF_W-1:0] sq_op;
    logic [SQ_W-1:0]         sq_res;
    logic signed [SQ_W:0]    threshold;
    logic [MASK_ROWS-1:0]    bank_mask;
    row_wr_t                 row_wr;

    // Q.8 to integer, truncated toward zero
    function automatic logic signed [I_W-1:0] trunc_q8(input logic signed [S_W-1:0] v);
        logic signed [I_W-1:0] q;
        q = I_W'(v >>> FRAC_BITS);
        if (v[S_W-1] && (v[FRAC_BITS-1:0] != '0))
        begin
            q = q + I_W'(1);
        end
        return q;
    endfunction

    // Grid coordinate in Q.8 minus a centre coordinate
    function automatic logic signed [DIFF_W-1:0] diff_of(
        input logic signed [I_W:0]  g,
        input logic signed [CW-1:0] c
    );
        logic signed [S_W+1:0] gs;
        logic signed [S_W+1:0] cs;
        logic signed [S_W+1:0] d;
        gs = (S_W+2)'(g) <<< FRAC_BITS;
        cs = (S_W+2)'(c);
        d  = gs - cs;
        return d[DIFF_W-1:0];
    endfunction

    // Bounding box of the circle
    always_comb
    begin
        cx_ext = S_W'(cx_reg);
        cy_ext = S_W'(cy_reg);
        r_ext  = S_W'({1'b0, r_reg});
        bx0    = trunc_q8(cx_ext - r_ext);
        bx1    = trunc_q8(cx_ext + r_ext);
        by0    = trunc_q8(cy_ext - r_ext);
        by1    = trunc_q8(cy_ext + r_ext);
        y_span = (I_W+1)'(by1) - (I_W+1)'(by0);
        if (y_span > $signed((I_W+1)'(MASK_ROWS - 1)))
        begin
            rows_last_calc = ROW_IDX_W'(MASK_ROWS - 1);
        end
        else
        begin
            rows_last_calc = y_span[ROW_IDX_W-1:0];
        end
    end

    assign r_in = RC_W'(s_axis_tdata[2*CW +: RADIUS_W]);
    assign yk   = (I_W+1)'(y0_reg) + (I_W+1)'({1'b0, k_reg});

    dgpr_sq_unit #(
        .DIFF_W (DIFF_W),
        .SQ_W   (SQ_W)
    ) u_sq (
        .clk     (clk),
        .operand (sq_op),
        .square  (sq_res)
    );

    dgpr_row_bank #(
        .SQ_W (SQ_W)
    ) u_rows (
        .clk       (clk),
        .wr        (row_wr),
        .wr_data   (sq_res),
        .rows_last (rows_last_reg),
        .threshold (threshold),
        .mask      (bank_mask)
    );

    // Sequencer: next state, unit operand and register updates
    always_comb
    begin
        state_next     = state_reg;
        dst_next       = DST_NONE;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        r_next         = r_reg;
        r2_next        = r2_reg;
        x_next         = x_reg;
        x1_next        = x1_reg;
        y0_next        = y0_reg;
        rows_last_next = rows_last_reg;
        k_next         = k_reg;
        widx_next      = widx_reg;
        col_next       = col_reg;
        ocol_next      = ocol_reg;
        orow_next      = orow_reg;
        omask_next     = omask_reg;
        olast_next     = olast_reg;
        done_next      = done_reg;
        sq_op          = '0;
        s_axis_tready  = 1'b0;
        m_axis_tvalid  = 1'b0;
        threshold      = $signed({1'b0, r2_reg}) - $signed({1'b0, sq_res});

        // Route the square that leaves the unit this cycle
        row_wr.en  = (dst_reg == DST_ROW);
        row_wr.idx = widx_reg;
        if (dst_reg == DST_R2)
        begin
            r2_next = sq_res;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cx_next = s_axis_tdata[CW-1:0];
                    cy_next = s_axis_tdata[2*CW-1:CW];
                    if (r_in > RC_W'(R_LIMIT))
                    begin
                        r_next = R_W'(R_LIMIT);
                    end
                    else
                    begin
                        r_next = R_W'(r_in);
                    end
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                x_next         = bx0;
                x1_next        = bx1;
                y0_next        = by0;
                rows_last_next = rows_last_calc;
                k_next         = '0;
                col_next       = '0;
                sq_op          = DIFF_W'($signed({1'b0, r_reg}));
                dst_next       = DST_R2;
                state_next     = ST_ROWS;
            end
            ST_ROWS:
            begin
                sq_op     = diff_of(yk, cy_reg);
                dst_next  = DST_ROW;
                widx_next = k_reg;
                if (k_reg == rows_last_reg)
                begin
                    state_next = ST_COL;
                end
                else
                begin
                    k_next = k_reg + ROW_IDX_W'(1);
                end
            end
            ST_COL:
            begin
                sq_op      = diff_of((I_W+1)'(x_reg), cx_reg);
                dst_next   = DST_DX;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                ocol_next  = XY_W'(x_reg);
                orow_next  = XY_W'(y0_reg);
                omask_next = bank_mask;
                olast_next = (x_reg == x1_reg);
                done_next  = (x_reg == x1_reg) || (col_reg == COL_W'(MAXC - 1));
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    if (done_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Advance to the next column and start its square at once
                        x_next     = x_reg + I_W'(1);
                        col_next   = col_reg + COL_W'(1);
                        sq_op      = diff_of((I_W+1)'(x_reg) + (I_W+1)'(1), cx_reg);
                        dst_next   = DST_DX;
                        state_next = ST_CMP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dst_reg   <= DST_NONE;
        end
        else
        begin
            state_reg <= state_next;
            dst_reg   <= dst_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        r_reg         <= r_next;
        r2_reg        <= r2_next;
        x_reg         <= x_next;
        x1_reg        <= x1_next;
        y0_reg        <= y0_next;
        rows_last_reg <= rows_last_next;
        k_reg         <= k_next;
        widx_reg      <= widx_next;
        col_reg       <= col_next;
        ocol_reg      <= ocol_next;
        orow_reg      <= orow_next;
        omask_reg     <= omask_next;
        olast_reg     <= olast_next;
        done_reg      <= done_next;
    end

    // Pack the result
    assign m_axis_tdata = {(OUT_TDATA_W - MASK_ROWS - 2 * XY_W)'(0), omask_reg, orow_reg,
                           ocol_reg};
    assign m_axis_tlast = olast_reg;

endmodule

[bench/disk_grid_point_rasterizer_tb.sv]
`timescale 1ns / 1ps

module disk_grid_point_rasterizer_tb;

    import dgpr_pkg::*;

    localparam int MAX_RADIUS     = 15;
    localparam int COORD_INT_BITS = 12;
    localparam int CW             = COORD_INT_BITS + FRAC_BITS;
    localparam int IN_W           = ((2 * CW + RADIUS_W + 7) / 8) * 8;
    localparam int GRID_ONE       = 1 << FRAC_BITS;
    localparam int MAX_COLUMNS    = 2 * MAX_RADIUS + 1;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int RANDOM_PER_PHASE = 55;

    // One column of a rasterised disk
    typedef struct {
        logic [XY_W-1:0]      column_x;
        logic [XY_W-1:0]      row_start;
        logic [MASK_ROWS-1:0] row_mask;
        logic                 last_column;
    } disk_column_t;

    // One directed circle, with its single column typed in where obvious
    typedef struct {
        logic [CW-1:0]        cx;
        logic [CW-1:0]        cy;
        logic [RADIUS_W-1:0]  rad;
        bit                   typed;
        logic [XY_W-1:0]      column_x;
        logic [XY_W-1:0]      row_start;
        logic [MASK_ROWS-1:0] row_mask;
    } directed_disk_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    disk_column_t   pending_columns[$];
    directed_disk_t directed_disks[$];
    int             mismatch_count;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_left;
    bit             hold_off_req;

    disk_grid_point_rasterizer #(
        .MAX_RADIUS     (MAX_RADIUS),
        .COORD_INT_BITS (COORD_INT_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Work out every column of one circle and queue them in order
    function automatic void rasterize_disk(input logic [CW-1:0] cx_bits,
                                           input logic [CW-1:0] cy_bits,
                                           input logic [RADIUS_W-1:0] rad_bits);
        longint       cx;
        longint       cy;
        longint       r;
        longint       r2;
        longint       x0;
        longint       x1;
        longint       y0;
        longint       y1;
        longint       rows;
        longint       xi;
        longint       dx;
        longint       dy;
        int           n;
        disk_column_t col;
        cx = longint'($signed(cx_bits));
        cy = longint'($signed(cy_bits));
        r  = longint'(rad_bits);
        // Saturate an oversized radius
        if (r > MAX_RADIUS * GRID_ONE)
            r = MAX_RADIUS * GRID_ONE;
        r2 = r * r;
        // Box edges truncate toward zero
        x0 = (cx - r) / GRID_ONE;
        x1 = (cx + r) / GRID_ONE;
        y0 = (cy - r) / GRID_ONE;
        y1 = (cy + r) / GRID_ONE;
        rows = y1 - y0 + 1;
        if (rows > MASK_ROWS)
            rows = MASK_ROWS;
        n = 0;
        for (xi = x0; xi <= x1 && n < MAX_COLUMNS; xi++)
        begin
            dx = xi * GRID_ONE - cx;
            col.row_mask = '0;
            for (int k = 0; k < rows; k++)
            begin
                dy = (y0 + k) * GRID_ONE - cy;
                col.row_mask[k] = (dx * dx + dy * dy <= r2);
            end
            col.column_x    = xi[XY_W-1:0];
            col.row_start   = y0[XY_W-1:0];
            col.last_column = (xi == x1);
            pending_columns.insert(pending_columns.size(), col);
            n++;
        end
    endfunction

    function automatic void add_disk(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                                     input logic [RADIUS_W-1:0] rad, input bit typed,
                                     input logic [XY_W-1:0] column_x,
                                     input logic [XY_W-1:0] row_start,
                                     input logic [MASK_ROWS-1:0] row_mask);
        directed_disk_t d;
        d.cx        = cx;
        d.cy        = cy;
        d.rad       = rad;
        d.typed     = typed;
        d.column_x  = column_x;
        d.row_start = row_start;
        d.row_mask  = row_mask;
        directed_disks.insert(directed_disks.size(), d);
    endfunction

    // Offer one request, idling at random first, and predict once it is taken
    task automatic send_request(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                                input logic [RADIUS_W-1:0] rad, input bit typed,
                                input disk_column_t typed_col);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - 2 * CW - RADIUS_W){1'b0}}, rad, cy, cx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (typed)
            pending_columns.insert(pending_columns.size(), typed_col);
        else
            rasterize_disk(cx, cy, rad);
    endtask

    // Count down the long sink hold-off once it is asked for
    always @(posedge clk)
    begin
        if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            hold_left = HOLD_OFF_LEN;
        end
        else if (hold_left > 0)
            hold_left--;
    end

    // Sink: check each column taken, then pick the next ready
    always @(posedge clk)
    begin
        disk_column_t exp_col;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_columns.size() == 0)
            begin
                $error("unexpected column: column_x %0d", $signed(m_axis_tdata[12:0]));
                mismatch_count++;
            end
            else
            begin
                exp_col = pending_columns.pop_front();
                if (m_axis_tdata[12:0] !== exp_col.column_x)
                begin
                    $error("column_x: expected %0d, got %0d",
                           $signed(exp_col.column_x), $signed(m_axis_tdata[12:0]));
                    mismatch_count++;
                end
                if (m_axis_tdata[25:13] !== exp_col.row_start)
                begin
                    $error("row_start: expected %0d, got %0d",
                           $signed(exp_col.row_start), $signed(m_axis_tdata[25:13]));
                    mismatch_count++;
                end
                if (m_axis_tdata[57:26] !== exp_col.row_mask)
                begin
                    $error("row_mask: expected %h, got %h",
                           exp_col.row_mask, m_axis_tdata[57:26]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== exp_col.last_column)
                begin
                    $error("last_column: expected %0d, got %0d",
                           exp_col.last_column, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
        // Hold off during the long stretch, else stall at random
        if (hold_left > 0)
            m_axis_tready <= 1'b0;
        else if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Main sequence: reset, directed table, random phases, drain
    initial
    begin
        logic [CW-1:0]       cx;
        logic [CW-1:0]       cy;
        logic [RADIUS_W-1:0] rad;
        disk_column_t        typed_col;
        int                  pick;

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        hold_off_req   = 1'b0;

        // Zero and tiny radius: single point only when the centre is on the grid
        add_disk(20'h00000, 20'h00000, 12'h000, 1, 13'sd0, 13'sd0, 32'h1);
        add_disk(20'h00080, 20'h00000, 12'h000, 1, 13'sd0, 13'sd0, 32'h0);
        add_disk(20'h00100, 20'h00200, 12'h000, 1, 13'sd1, 13'sd2, 32'h1);
        add_disk(20'hFFFFF, 20'hFFFFF, 12'h000, 1, 13'sd0, 13'sd0, 32'h0);
        add_disk(20'h00000, 20'h00000, 12'h001, 1, 13'sd0, 13'sd0, 32'h1);
        // Coordinate extremes
        add_disk(20'h7FFFF, 20'h80000, 12'h000, 1, 13'sd2047, -13'sd2048, 32'h0);
        add_disk(20'h80000, 20'h7FFFF, 12'h000, 1, -13'sd2048, 13'sd2047, 32'h0);
        add_disk(20'h80000, 20'h80000, 12'h000, 1, -13'sd2048, -13'sd2048, 32'h1);
        add_disk(20'h7FFFF, 20'h7FFFF, 12'hF00, 0, '0, '0, '0);
        add_disk(20'h80000, 20'h80000, 12'hF00, 0, '0, '0, '0);
        add_disk(20'h7FFFF, 20'h80000, 12'hFFF, 0, '0, '0, '0);
        // Largest radius, and radius above the limit
        add_disk(20'h00000, 20'h00000, 12'hF00, 0, '0, '0, '0);
        add_disk(20'h00000, 20'h00000, 12'hF01, 0, '0, '0, '0);
        add_disk(20'h00000, 20'h00000, 12'hFFF, 0, '0, '0, '0);
        add_disk(20'h00080, 20'h00080, 12'hF00, 0, '0, '0, '0);
        // Empty columns and truncation about zero
        add_disk(20'h00080, 20'h00080, 12'h080, 0, '0, '0, '0);
        add_disk(20'hFFE80, 20'hFFF80, 12'h200, 0, '0, '0, '0);
        add_disk(20'h0007F, 20'hFFF81, 12'hFFF, 0, '0, '0, '0);
        add_disk(20'h00000, 20'h00000, 12'h100, 0, '0, '0, '0);
        add_disk(20'h00000, 20'h00000, 12'h0FF, 0, '0, '0, '0);
        add_disk(20'h12345, 20'hABCDE, 12'h955, 0, '0, '0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_disks[i])
        begin
            typed_col.column_x    = directed_disks[i].column_x;
            typed_col.row_start   = directed_disks[i].row_start;
            typed_col.row_mask    = directed_disks[i].row_mask;
            typed_col.last_column = 1'b1;
            send_request(directed_disks[i].cx, directed_disks[i].cy, directed_disks[i].rad,
                         directed_disks[i].typed, typed_col);
        end

        // Random circles over the idling phases
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Back the sink off once while requests keep coming
                if (phase == 0 && n == 10)
                    hold_off_req = 1'b1;
                pick = $urandom_range(99);
                if (pick < 60)
                    rad = RADIUS_W'($urandom_range(1024, 0));
                else if (pick < 90)
                    rad = RADIUS_W'($urandom_range(MAX_RADIUS * GRID_ONE, 0));
                else
                    rad = RADIUS_W'($urandom_range(4095, MAX_RADIUS * GRID_ONE + 1));
                // Keep some centres near zero, where truncation changes sense
                if ($urandom_range(3) == 0)
                begin
                    cx = CW'($urandom_range(2047, 0) - 1024);
                    cy = CW'($urandom_range(2047, 0) - 1024);
                end
                else
                begin
                    cx = CW'($urandom());
                    cy = CW'($urandom());
                end
                send_request(cx, cy, rad, 0, typed_col);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow for any stray output
        while (pending_columns.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
src/dgpr_pkg.sv
src/dgpr_sq_unit.sv
src/dgpr_row_bank.sv
src/disk_grid_point_rasterizer.sv
bench/disk_grid_point_rasterizer_tb.sv
